### src/wspm_pkg.sv
// wspm_pkg: shared types and constants for the wildcard star pattern matcher
// no dependencies; used by wspm_row and wildcard_star_pattern_matcher
package wspm_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  localparam logic [7:0] SymStar = 8'h2A;
  localparam logic [7:0] SymAny  = 8'h2E;

endpackage

### src/wspm_row.sv
// wspm_row: next prefix-match row for one text byte, and the empty-text row
// depends on wspm_pkg for the special pattern symbols
module wspm_row #(
  parameter int PATTERN_MAX = 32,
  localparam int LenW = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX-1:0][7:0] pat,
  input  logic [LenW-1:0]             step_len,
  input  logic [PATTERN_MAX:0]        old_row,
  input  logic [7:0]                  sym,
  input  logic [PATTERN_MAX-1:0]      arm_star,
  input  logic [LenW-1:0]             arm_len,
  output logic [PATTERN_MAX:0]        step_row,
  output logic [PATTERN_MAX:0]        arm_row
);

  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX-1:0] star;
  logic [PATTERN_MAX:0]   step_live;
  logic [PATTERN_MAX:0]   arm_live;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      hit[i]  = (pat[i] == wspm_pkg::SymAny) || (pat[i] == sym);
      star[i] = (pat[i] == wspm_pkg::SymStar);
    end
    for (int j = 0; j <= PATTERN_MAX; j++) begin
      step_live[j] = (LenW'(j) <= step_len);
      arm_live[j]  = (LenW'(j) <= arm_len);
    end
  end

  // star bits chain through row[j-2], like a carry through the star positions
  always_comb begin
    step_row    = '0;
    step_row[0] = 1'b0;
    for (int j = 1; j <= PATTERN_MAX; j++) begin
      if (star[j-1]) begin
        if (j >= 2) begin
          step_row[j] = step_live[j] & (step_row[j-2] | (hit[j-2] & old_row[j]));
        end else begin
          step_row[j] = 1'b0;
        end
      end else begin
        step_row[j] = step_live[j] & old_row[j-1] & hit[j-1];
      end
    end
  end

  // empty text: only star pairs can be skipped; a leading star matches nothing
  always_comb begin
    arm_row    = '0;
    arm_row[0] = 1'b1;
    for (int j = 2; j <= PATTERN_MAX; j++) begin
      arm_row[j] = arm_live[j] & arm_star[j-1] & arm_row[j-2];
    end
  end

endmodule

### src/wildcard_star_pattern_matcher.sv
// wildcard_star_pattern_matcher: whole-text match against a '.' / '*' pattern
// depends on wspm_pkg and wspm_row
//
//  channel | signals                         | beat carries
//  --------+---------------------------------+-------------------------------
//  in      | in_valid, in_stall              | action, symbol
//  out     | out_valid, out_stall            | matched, overflow (end only)
//
// one beat per cycle while in_stall is low; a beat is held in the input register, then
// the row update and, for an end beat, the result register take it
// an end beat gives its result from the result register, after the input register
// reset empties the pattern, clears the overflow flag and arms the empty row
// in_stall rises only when an end beat waits behind a stalled result
module wildcard_star_pattern_matcher #(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic       overflow
);

  localparam int LenW = $clog2(PATTERN_MAX + 1);
  localparam int IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // input register
  logic              s1_valid;
  wspm_pkg::action_t s1_action;
  logic [7:0]        s1_symbol;

  // matcher state
  logic [PATTERN_MAX-1:0][7:0] pat;
  logic [LenW-1:0]             len;
  logic                        ovf;
  logic [PATTERN_MAX:0]        row;

  logic                   s1_go;
  logic                   proc;
  logic                   room;
  logic                   do_append;
  logic [PATTERN_MAX-1:0] star_cur;
  logic [PATTERN_MAX-1:0] arm_star;
  logic [LenW-1:0]        arm_len;
  logic [PATTERN_MAX:0]   step_row;
  logic [PATTERN_MAX:0]   arm_row;

  assign s1_go     = (s1_action != wspm_pkg::ACT_END) || !out_valid || !out_stall;
  assign proc      = s1_valid && s1_go;
  assign in_stall  = s1_valid && !s1_go;
  assign room      = (len < LenW'(PATTERN_MAX));
  assign do_append = proc && (s1_action == wspm_pkg::ACT_APPEND) && room;

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      star_cur[i] = (pat[i] == wspm_pkg::SymStar);
    end
    arm_star = star_cur;
    arm_len  = len;
    if (do_append) begin
      arm_star[len[IdxW-1:0]] = (s1_symbol == wspm_pkg::SymStar);
      arm_len                 = len + LenW'(1);
    end else if (s1_action == wspm_pkg::ACT_CLEAR) begin
      arm_len = '0;
    end
  end

  wspm_row #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_row (
    .pat      (pat),
    .step_len (len),
    .old_row  (row),
    .sym      (s1_symbol),
    .arm_star (arm_star),
    .arm_len  (arm_len),
    .step_row (step_row),
    .arm_row  (arm_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action <= wspm_pkg::action_t'(action);
      s1_symbol <= symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      pat[len[IdxW-1:0]] <= s1_symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ovf <= 1'b0;
      row <= (PATTERN_MAX + 1)'(1);
    end else if (proc) begin
      unique case (s1_action)
        wspm_pkg::ACT_CLEAR: begin
          len <= '0;
          ovf <= 1'b0;
          row <= arm_row;
        end
        wspm_pkg::ACT_APPEND: begin
          if (room) begin
            len <= len + LenW'(1);
          end else begin
            ovf <= 1'b1;
          end
          row <= arm_row;
        end
        wspm_pkg::ACT_TEXT: begin
          row <= step_row;
        end
        wspm_pkg::ACT_END: begin
          row <= arm_row;
        end
        default: begin
          row <= arm_row;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && (s1_action == wspm_pkg::ACT_END)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && (s1_action == wspm_pkg::ACT_END)) begin
      matched  <= row[len];
      overflow <= ovf;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LenW'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    proc && (s1_action == wspm_pkg::ACT_END) |=> out_valid)
    else $error("end beat gave no result");

  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    proc && (s1_action == wspm_pkg::ACT_CLEAR) |=>
      (len == '0) && !ovf && (row == (PATTERN_MAX + 1)'(1)))
    else $error("clear left stale state");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && (s1_action == wspm_pkg::ACT_END) && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule
